// ----- src/lav_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg: shared types and constants of the view matrix builder
// Word width, status codes and column numbering used by the channels and core.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int WORD_W    = 32;
	// Magnitudes are normalized so that the largest one lies in [2^29, 2^30).
	localparam int NORM_BITS = 30;

	typedef logic [1:0] col_t;
	localparam col_t COL_LAST = 2'd3;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_EYE_AT_TGT  = 2'd1,
		STATUS_UP_PARALLEL = 2'd2
	} status_t;

endpackage

// ----- src/lav_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_item_if: input channel of the view matrix builder
// Carries eye, target and up vectors in signed fixed point with valid/ready.
// ----------------------------------------------------------------------------
interface lav_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [lav_pkg::WORD_W-1:0]   eye_x;
	logic signed [lav_pkg::WORD_W-1:0]   eye_y;
	logic signed [lav_pkg::WORD_W-1:0]   eye_z;
	logic signed [lav_pkg::WORD_W-1:0]   target_x;
	logic signed [lav_pkg::WORD_W-1:0]   target_y;
	logic signed [lav_pkg::WORD_W-1:0]   target_z;
	logic signed [lav_pkg::WORD_W-1:0]   up_x;
	logic signed [lav_pkg::WORD_W-1:0]   up_y;
	logic signed [lav_pkg::WORD_W-1:0]   up_z;

	modport source (
		output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		       up_x, up_y, up_z,
		input  ready
	);
	modport sink (
		input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		       up_x, up_y, up_z,
		output ready
	);
endinterface

// ----- src/lav_col_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_col_if: result channel of the view matrix builder
// Carries one matrix column per transfer with valid/ready.
// ----------------------------------------------------------------------------
interface lav_col_if;
	logic                                valid;
	logic                                ready;
	lav_pkg::col_t                       column_index;
	logic signed [lav_pkg::WORD_W-1:0]   entry_row0;
	logic signed [lav_pkg::WORD_W-1:0]   entry_row1;
	logic signed [lav_pkg::WORD_W-1:0]   entry_row2;
	logic signed [lav_pkg::WORD_W-1:0]   entry_row3;
	logic                                last_column;
	lav_pkg::status_t                    status;

	modport source (
		output valid, column_index, entry_row0, entry_row1, entry_row2, entry_row3,
		       last_column, status,
		input  ready
	);
	modport sink (
		input  valid, column_index, entry_row0, entry_row1, entry_row2, entry_row3,
		       last_column, status,
		output ready
	);
endinterface

// ----- src/lav_unit_vec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit_vec: pipelined normalization of a signed 3-vector
// Scales magnitudes to a common exponent, takes a bit-per-stage square root
// of the sum of squares and divides each component by it one quotient bit
// per stage. A side word travels alongside every item.
// ----------------------------------------------------------------------------
module lav_unit_vec #(
	parameter int W         = 33,
	parameter int FRAC_BITS = 16,
	parameter int SW        = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [W-1:0]       vec [3],
	input  logic [SW-1:0]             side_in,
	output logic                      out_valid,
	output logic signed [FRAC_BITS+1:0] uvec [3],
	output logic [SW-1:0]             side_out
);

	localparam int NB    = lav_pkg::NORM_BITS;
	localparam int BCW   = $clog2(W + 1);
	localparam int ISQ   = NB + 2;
	localparam int RAD_W = 2 * ISQ - 1;
	localparam int LEN_W = NB + 1;
	localparam int QW    = FRAC_BITS + 1;
	localparam int RW    = LEN_W + FRAC_BITS;

	function automatic logic [BCW-1:0] lead_bits(input logic [W-1:0] x);
		logic [BCW-1:0] b;
		b = '0;
		for (int i = 0; i < W; i++) begin
			if (x[i]) b = BCW'(i + 1);
		end
		return b;
	endfunction

	// Stage 1: magnitudes and their maximum.
	logic [W-1:0]     mag [3];
	logic [W-1:0]     mx;
	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [W-1:0]     m_s1 [3];
	logic [W-1:0]     mx_s1;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SW-1:0]    side_s1, side_s2, side_s3, side_s4;
	logic [W-1:0]     m_s2 [3];
	logic             shr_s2;
	logic [BCW-1:0]   sha_s2;
	logic [BCW-1:0]   lb;
	logic [NB-1:0]    a_s3 [3];
	logic [NB-1:0]    a_s4 [3];
	logic [2*NB-1:0]  sq_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
		end
		mx = mag[0];
		if (mag[1] > mx) mx = mag[1];
		if (mag[2] > mx) mx = mag[2];
	end

	assign lb = lead_bits(mx_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]   <= mag[i];
				neg_s1[i] <= vec[i][W-1];
			end
			mx_s1   <= mx;
			side_s1 <= side_in;

			// Stage 2: shift that brings the largest magnitude into range.
			m_s2    <= m_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			shr_s2  <= lb > BCW'(NB);
			sha_s2  <= (lb > BCW'(NB)) ? lb - BCW'(NB) : BCW'(NB) - lb;

			// Stage 3: apply the shift.
			for (int i = 0; i < 3; i++) begin
				a_s3[i] <= shr_s2 ? NB'(m_s2[i] >> sha_s2) : (NB'(m_s2[i]) << sha_s2);
			end
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;

			// Stage 4: squares.
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= a_s3[i] * a_s3[i];
			end
			a_s4    <= a_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
		end
	end

	// Square root: one result bit per stage.
	logic [RAD_W-1:0] x_si    [ISQ+1];
	logic [RAD_W-1:0] r_si    [ISQ+1];
	logic [NB-1:0]    a_si    [ISQ+1][3];
	logic [2:0]       neg_si  [ISQ+1];
	logic [SW-1:0]    side_si [ISQ+1];
	logic             vld_si  [ISQ+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_si[0]    <= RAD_W'(sq_s4[0]) + RAD_W'(sq_s4[1]) + RAD_W'(sq_s4[2]);
			r_si[0]    <= '0;
			a_si[0]    <= a_s4;
			neg_si[0]  <= neg_s4;
			side_si[0] <= side_s4;
		end
	end

	for (genvar k = 0; k < ISQ; k++) begin : g_isq
		localparam logic [RAD_W-1:0] BITK = RAD_W'(1) << (2 * (ISQ - 1 - k));
		logic [RAD_W-1:0] trial;
		assign trial = r_si[k] + BITK;

		always_ff @(posedge clk) begin
			if (en) begin
				if (x_si[k] >= trial) begin
					x_si[k+1] <= x_si[k] - trial;
					r_si[k+1] <= (r_si[k] >> 1) + BITK;
				end else begin
					x_si[k+1] <= x_si[k];
					r_si[k+1] <= r_si[k] >> 1;
				end
				a_si[k+1]    <= a_si[k];
				neg_si[k+1]  <= neg_si[k];
				side_si[k+1] <= side_si[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_si[k+1] <= 1'b0;
			end else if (en) begin
				vld_si[k+1] <= vld_si[k];
			end
		end
	end

	// Division: one quotient bit per stage, three components side by side.
	logic [RW-1:0]    rem_sd  [QW+1][3];
	logic [QW-1:0]    q_sd    [QW+1][3];
	logic [LEN_W-1:0] len_sd  [QW+1];
	logic [2:0]       neg_sd  [QW+1];
	logic [SW-1:0]    side_sd [QW+1];
	logic             vld_sd  [QW+1];
	logic [LEN_W-1:0] len_fin;

	assign len_fin = r_si[ISQ][LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_sd[0][i] <= (RW'(a_si[ISQ][i]) << FRAC_BITS) + RW'(len_fin >> 1);
				q_sd[0][i]   <= '0;
			end
			len_sd[0]  <= len_fin;
			neg_sd[0]  <= neg_si[ISQ];
			side_sd[0] <= side_si[ISQ];
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [RW-1:0] dvs;
		assign dvs = RW'(len_sd[k]) << (QW - 1 - k);

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_sd[k][i] >= dvs) begin
						rem_sd[k+1][i] <= rem_sd[k][i] - dvs;
						q_sd[k+1][i]   <= {q_sd[k][i][QW-2:0], 1'b1};
					end else begin
						rem_sd[k+1][i] <= rem_sd[k][i];
						q_sd[k+1][i]   <= {q_sd[k][i][QW-2:0], 1'b0};
					end
				end
				len_sd[k+1]  <= len_sd[k];
				neg_sd[k+1]  <= neg_sd[k];
				side_sd[k+1] <= side_sd[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (en) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_si[0] <= 1'b0;
			vld_sd[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_si[0] <= vld_s4;
			vld_sd[0] <= vld_si[ISQ];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uvec[i] = neg_sd[QW][i] ? -$signed({1'b0, q_sd[QW][i]})
			                        :  $signed({1'b0, q_sd[QW][i]});
		end
	end

	assign out_valid = vld_sd[QW];
	assign side_out  = side_sd[QW];

endmodule

// ----- src/look_at_view_matrix_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: fixed-point look-at view matrix builder
// Builds the 4x4 view matrix from eye, target and up and sends it out as
// four column transfers in column-major order.
// ----------------------------------------------------------------------------
//
//   Channel  Modport  Width per transfer   Contents
//   item     sink     9 x 32 bits          eye, target, up (signed fixed point)
//   result   source   2+4x32+1+2 bits      column index, four rows, last, status
//
// Pipeline: the datapath is one pipeline of 2*FRAC_BITS+86 stages (118 at the
// default) followed by a column register. Every item produces four result
// transfers; the result port sends one column per cycle while result.ready is
// high and so sets the sustained rate of items, since the pipeline takes a new
// item before the last one has left it.
// Reset clears only valid bits and the column sequencer. A stall on the result
// side holds the whole pipeline, bubbles included, only while its last stage
// holds a matrix that the column register cannot yet take.
//
module look_at_view_matrix_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	lav_item_if.sink         item,
	lav_col_if.source        result
);

	localparam int WW  = lav_pkg::WORD_W;
	localparam int NW  = FRAC_BITS + 2;   // unit vector component
	localparam int VW  = FRAC_BITS + 3;   // second cross product component
	localparam int PW  = FRAC_BITS + 34;  // 32-bit word times a unit component
	localparam int CW  = FRAC_BITS + 35;  // cross product of up with n
	localparam int DW  = FRAC_BITS + 37;  // dot products and rounding
	localparam logic [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
	localparam logic signed [WW-1:0] ONE = WW'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0][WW-1:0] eye;
		logic [2:0][WW-1:0] up;
		logic               dzero;
	} side_n_t;

	typedef struct packed {
		logic [2:0][WW-1:0] eye;
		logic [2:0][NW-1:0] n;
		lav_pkg::status_t   st;
	} side_u_t;

	// Shift right by FRAC_BITS, rounding half away from zero.
	function automatic logic signed [DW-1:0] rshift(input logic signed [DW-1:0] x);
		logic [DW-1:0] m;
		m = x[DW-1] ? DW'(-x) : DW'(x);
		m = (m + HALF) >> FRAC_BITS;
		return x[DW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [WW-1:0] sat32(input logic signed [DW-1:0] x);
		logic [DW-WW:0] top;
		top = x[DW-1:WW-1];
		if (top == '0 || top == '1) begin
			return x[WW-1:0];
		end
		return x[DW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
	endfunction

	function automatic logic signed [WW-1:0] trans(input logic signed [DW-1:0] dot);
		return sat32(-rshift(dot));
	endfunction

	// Pipeline advances unless the last stage holds a matrix that cannot move.
	logic adv;
	logic ser_load;

	// Stage 1: eye minus target.
	logic                 vld_s1;
	logic signed [WW-1:0] eye_s1 [3];
	logic signed [WW-1:0] up_s1  [3];
	logic signed [WW:0]   d_s1   [3];
	logic                 dz_s1;
	side_n_t              side_n_in, side_n_out;

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s1[0] <= item.eye_x;
			eye_s1[1] <= item.eye_y;
			eye_s1[2] <= item.eye_z;
			up_s1[0]  <= item.up_x;
			up_s1[1]  <= item.up_y;
			up_s1[2]  <= item.up_z;
			d_s1[0]   <= (WW+1)'(item.eye_x) - (WW+1)'(item.target_x);
			d_s1[1]   <= (WW+1)'(item.eye_y) - (WW+1)'(item.target_y);
			d_s1[2]   <= (WW+1)'(item.eye_z) - (WW+1)'(item.target_z);
			dz_s1     <= (item.eye_x == item.target_x) && (item.eye_y == item.target_y) &&
			             (item.eye_z == item.target_z);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_n_in.eye[i] = eye_s1[i];
			side_n_in.up[i]  = up_s1[i];
		end
		side_n_in.dzero = dz_s1;
	end

	logic                 n_vld;
	logic signed [NW-1:0] n_u [3];

	lav_unit_vec #(
		.W         (WW + 1),
		.FRAC_BITS (FRAC_BITS),
		.SW        ($bits(side_n_t))
	) u_norm_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.vec       (d_s1),
		.side_in   (side_n_in),
		.out_valid (n_vld),
		.uvec      (n_u),
		.side_out  (side_n_out)
	);

	// Stage 2: products of up with n.
	logic                 vld_s2;
	logic signed [WW-1:0] eye_s2 [3];
	logic signed [NW-1:0] n_s2   [3];
	logic signed [PW-1:0] p_s2   [6];
	logic                 dz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				eye_s2[i] <= $signed(side_n_out.eye[i]);
				n_s2[i]   <= n_u[i];
			end
			p_s2[0] <= $signed(side_n_out.up[1]) * n_u[2];
			p_s2[1] <= $signed(side_n_out.up[2]) * n_u[1];
			p_s2[2] <= $signed(side_n_out.up[2]) * n_u[0];
			p_s2[3] <= $signed(side_n_out.up[0]) * n_u[2];
			p_s2[4] <= $signed(side_n_out.up[0]) * n_u[1];
			p_s2[5] <= $signed(side_n_out.up[1]) * n_u[0];
			dz_s2   <= side_n_out.dzero;
		end
	end

	// Stage 3: cross product up x n and the status of the item.
	logic                 vld_s3;
	logic signed [CW-1:0] c_s3 [3];
	side_u_t              side_u_in, side_u_out;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s3[0] <= CW'(p_s2[0]) - CW'(p_s2[1]);
			c_s3[1] <= CW'(p_s2[2]) - CW'(p_s2[3]);
			c_s3[2] <= CW'(p_s2[4]) - CW'(p_s2[5]);
			for (int i = 0; i < 3; i++) begin
				side_u_in.eye[i] <= eye_s2[i];
				side_u_in.n[i]   <= n_s2[i];
			end
			// Eye at target wins over up parallel to the view direction.
			if (dz_s2) begin
				side_u_in.st <= lav_pkg::STATUS_EYE_AT_TGT;
			end else if (p_s2[0] == p_s2[1] && p_s2[2] == p_s2[3] && p_s2[4] == p_s2[5]) begin
				side_u_in.st <= lav_pkg::STATUS_UP_PARALLEL;
			end else begin
				side_u_in.st <= lav_pkg::STATUS_OK;
			end
		end
	end

	logic                 u_vld;
	logic signed [NW-1:0] u_u [3];

	lav_unit_vec #(
		.W         (CW),
		.FRAC_BITS (FRAC_BITS),
		.SW        ($bits(side_u_t))
	) u_norm_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.vec       (c_s3),
		.side_in   (side_u_in),
		.out_valid (u_vld),
		.uvec      (u_u),
		.side_out  (side_u_out)
	);

	// Stage 4: products for v = n x u and for the u and n dot products.
	logic                   vld_s4;
	logic signed [NW-1:0]   u_s4 [3];
	logic signed [NW-1:0]   n_s4 [3];
	logic signed [WW-1:0]   eye_s4 [3];
	logic signed [2*NW-1:0] nu_s4 [6];
	logic signed [PW-1:0]   ue_s4 [3];
	logic signed [PW-1:0]   ne_s4 [3];
	lav_pkg::status_t       st_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				u_s4[i]   <= u_u[i];
				n_s4[i]   <= $signed(side_u_out.n[i]);
				eye_s4[i] <= $signed(side_u_out.eye[i]);
				ue_s4[i]  <= u_u[i] * $signed(side_u_out.eye[i]);
				ne_s4[i]  <= $signed(side_u_out.n[i]) * $signed(side_u_out.eye[i]);
			end
			nu_s4[0] <= $signed(side_u_out.n[1]) * u_u[2];
			nu_s4[1] <= $signed(side_u_out.n[2]) * u_u[1];
			nu_s4[2] <= $signed(side_u_out.n[2]) * u_u[0];
			nu_s4[3] <= $signed(side_u_out.n[0]) * u_u[2];
			nu_s4[4] <= $signed(side_u_out.n[0]) * u_u[1];
			nu_s4[5] <= $signed(side_u_out.n[1]) * u_u[0];
			st_s4    <= side_u_out.st;
		end
	end

	// Stage 5: v rounded back to FRAC_BITS; u and n dot products summed.
	logic                 vld_s5;
	logic signed [NW-1:0] u_s5 [3];
	logic signed [NW-1:0] n_s5 [3];
	logic signed [VW-1:0] v_s5 [3];
	logic signed [WW-1:0] eye_s5 [3];
	logic signed [DW-1:0] su_s5, sn_s5;
	lav_pkg::status_t     st_s5;
	logic signed [DW-1:0] vr [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vr[i] = rshift(DW'(nu_s4[2*i]) - DW'(nu_s4[2*i+1]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				v_s5[i] <= vr[i][VW-1:0];
			end
			su_s5  <= DW'(ue_s4[0]) + DW'(ue_s4[1]) + DW'(ue_s4[2]);
			sn_s5  <= DW'(ne_s4[0]) + DW'(ne_s4[1]) + DW'(ne_s4[2]);
			u_s5   <= u_s4;
			n_s5   <= n_s4;
			eye_s5 <= eye_s4;
			st_s5  <= st_s4;
		end
	end

	// Stage 6: v dot products; u and n translations finished.
	logic                    vld_s6;
	logic signed [NW-1:0]    u_s6 [3];
	logic signed [NW-1:0]    n_s6 [3];
	logic signed [VW-1:0]    v_s6 [3];
	logic signed [VW+WW-1:0] ve_s6 [3];
	logic signed [WW-1:0]    tu_s6, tn_s6;
	lav_pkg::status_t        st_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ve_s6[i] <= v_s5[i] * eye_s5[i];
			end
			tu_s6 <= trans(su_s5);
			tn_s6 <= trans(sn_s5);
			u_s6  <= u_s5;
			n_s6  <= n_s5;
			v_s6  <= v_s5;
			st_s6 <= st_s5;
		end
	end

	// Stage 7: sum of the v dot product.
	logic                 vld_s7;
	logic signed [NW-1:0] u_s7 [3];
	logic signed [NW-1:0] n_s7 [3];
	logic signed [VW-1:0] v_s7 [3];
	logic signed [DW-1:0] sv_s7;
	logic signed [WW-1:0] tu_s7, tn_s7;
	lav_pkg::status_t     st_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			sv_s7 <= DW'(ve_s6[0]) + DW'(ve_s6[1]) + DW'(ve_s6[2]);
			u_s7  <= u_s6;
			n_s7  <= n_s6;
			v_s7  <= v_s6;
			tu_s7 <= tu_s6;
			tn_s7 <= tn_s6;
			st_s7 <= st_s6;
		end
	end

	// Stage 8: the matrix, saturated and forced to zero on a degenerate item.
	logic                 vld_s8;
	logic signed [WW-1:0] mat_s8 [4][3];
	lav_pkg::status_t     st_s8;
	logic signed [WW-1:0] mat_nx [4][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mat_nx[k][0] = sat32(DW'(u_s7[k]));
			mat_nx[k][1] = sat32(DW'(v_s7[k]));
			mat_nx[k][2] = sat32(DW'(n_s7[k]));
		end
		mat_nx[3][0] = tu_s7;
		mat_nx[3][1] = trans(sv_s7);
		mat_nx[3][2] = tn_s7;
		if (st_s7 != lav_pkg::STATUS_OK) begin
			for (int k = 0; k < 4; k++) begin
				for (int r = 0; r < 3; r++) begin
					mat_nx[k][r] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_s8 <= mat_nx;
			st_s8  <= st_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item.valid;
			vld_s2 <= n_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= u_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Column register: holds one matrix and walks through its four columns.
	logic                 ser_vld_q;
	lav_pkg::col_t        col_q;
	logic signed [WW-1:0] mat_q [4][3];
	lav_pkg::status_t     st_q;

	assign ser_load = !ser_vld_q || (result.ready && col_q == lav_pkg::COL_LAST);
	assign adv      = !vld_s8 || ser_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			col_q     <= '0;
		end else if (ser_load) begin
			ser_vld_q <= vld_s8;
			col_q     <= '0;
		end else if (result.ready) begin
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load && vld_s8) begin
			mat_q <= mat_s8;
			st_q  <= st_s8;
		end
	end

	assign item.ready          = adv;
	assign result.valid        = ser_vld_q;
	assign result.column_index = col_q;
	assign result.entry_row0   = mat_q[col_q][0];
	assign result.entry_row1   = mat_q[col_q][1];
	assign result.entry_row2   = mat_q[col_q][2];
	assign result.entry_row3   = (col_q == lav_pkg::COL_LAST && st_q == lav_pkg::STATUS_OK)
	                             ? ONE : '0;
	assign result.last_column  = col_q == lav_pkg::COL_LAST;
	assign result.status       = st_q;

endmodule
